>>> hw/rtl/i2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2d_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned DigitN  = 10;
  localparam int unsigned BcdW    = 4 * DigitN;
  localparam int unsigned IterW   = $clog2(WordW);
  localparam int unsigned LeftW   = $clog2(DigitN + 1);
  localparam int unsigned LenW    = 4;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CharW-1:0] AsciiZero  = 8'h30;
  localparam logic [CharW-1:0] AsciiMinus = 8'h2D;
  localparam logic [CharW-1:0] TermReset  = 8'h20;
  localparam logic             SignedReset = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgSignedMode = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTermChar   = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ctl_state_e;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SIGN,
    EM_DIGIT,
    EM_TERM
  } emit_state_e;

  typedef struct packed {
    logic             neg;
    logic [CharW-1:0] term;
  } emit_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2d_dabble.sv
`timescale 1ns / 1ps
`default_nettype none

// shift-and-add-3 binary to BCD, one bit per cycle
module i2d_dabble (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [i2d_pkg::WordW-1:0]   value_i,
  output logic                             done_o,
  output logic      [i2d_pkg::BcdW-1:0]    bcd_o
);

  logic [i2d_pkg::WordW-1:0] bin_q, bin_d;
  logic [i2d_pkg::BcdW-1:0]  bcd_q, bcd_d, bcd_adj;
  logic [i2d_pkg::IterW-1:0] cnt_q, cnt_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;

  always_comb begin
    for (int i = 0; i < int'(i2d_pkg::DigitN); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {bcd_adj[i2d_pkg::BcdW-2:0], bin_q[i2d_pkg::WordW-1]};
      bin_d = {bin_q[i2d_pkg::WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == i2d_pkg::IterW'(i2d_pkg::WordW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

>>> hw/rtl/i2d_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module i2d_emit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [i2d_pkg::BcdW-1:0]    bcd_i,
  input  wire i2d_pkg::emit_cfg_t          cfg_i,
  output logic                             done_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [i2d_pkg::CharW-1:0]   character_o,
  output logic                             last_o,
  output logic      [i2d_pkg::LenW-1:0]    length_o
);

  i2d_pkg::emit_state_e state_q, state_d;

  logic [i2d_pkg::BcdW-1:0]  bcd_q, bcd_d;
  logic [i2d_pkg::LeftW-1:0] left_q, left_d;
  logic [i2d_pkg::LenW-1:0]  len_q, len_d;
  logic                      vld_q, vld_d;
  logic [i2d_pkg::CharW-1:0] chr_q, chr_d;
  logic                      last_q, last_d;
  logic [i2d_pkg::LenW-1:0]  olen_q, olen_d;
  logic                      free;
  logic [3:0]                top_dig;

  assign free    = !vld_q || !out_stall_i;
  assign top_dig = bcd_q[i2d_pkg::BcdW-1 -: 4];

  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    left_d  = left_q;
    len_d   = len_q;
    vld_d   = vld_q && out_stall_i;
    chr_d   = chr_q;
    last_d  = last_q;
    olen_d  = olen_q;
    done_o  = 1'b0;
    case (state_q)
      i2d_pkg::EM_IDLE: begin
        if (start_i) begin
          bcd_d   = bcd_i;
          left_d  = i2d_pkg::LeftW'(i2d_pkg::DigitN);
          state_d = i2d_pkg::EM_SKIP;
        end
      end
      i2d_pkg::EM_SKIP: begin
        if (top_dig == 4'd0 && left_q > i2d_pkg::LeftW'(1)) begin
          bcd_d  = {bcd_q[i2d_pkg::BcdW-5:0], 4'd0};
          left_d = left_q - 1'b1;
        end else begin
          len_d   = i2d_pkg::LenW'(left_q) + i2d_pkg::LenW'(cfg_i.neg) + 4'd1;
          state_d = cfg_i.neg ? i2d_pkg::EM_SIGN : i2d_pkg::EM_DIGIT;
        end
      end
      i2d_pkg::EM_SIGN: begin
        if (free) begin
          vld_d   = 1'b1;
          chr_d   = i2d_pkg::AsciiMinus;
          last_d  = 1'b0;
          olen_d  = '0;
          state_d = i2d_pkg::EM_DIGIT;
        end
      end
      i2d_pkg::EM_DIGIT: begin
        if (free) begin
          vld_d  = 1'b1;
          chr_d  = i2d_pkg::AsciiZero + {4'd0, top_dig};
          last_d = 1'b0;
          olen_d = '0;
          bcd_d  = {bcd_q[i2d_pkg::BcdW-5:0], 4'd0};
          left_d = left_q - 1'b1;
          if (left_q == i2d_pkg::LeftW'(1)) begin
            state_d = i2d_pkg::EM_TERM;
          end
        end
      end
      i2d_pkg::EM_TERM: begin
        if (free) begin
          vld_d   = 1'b1;
          chr_d   = cfg_i.term;
          last_d  = 1'b1;
          olen_d  = len_q;
          done_o  = 1'b1;
          state_d = i2d_pkg::EM_IDLE;
        end
      end
      default: begin
        state_d = i2d_pkg::EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2d_pkg::EM_IDLE;
      left_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    len_q  <= len_d;
    chr_q  <= chr_d;
    last_q <= last_d;
    olen_q <= olen_d;
  end

  assign out_valid_o = vld_q;
  assign character_o = chr_q;
  assign last_o      = last_q;
  assign length_o    = olen_q;

endmodule

`default_nettype wire

>>> hw/rtl/integer_to_decimal_ascii.sv
`timescale 1ns / 1ps
`default_nettype none

// Prints one 32-bit word per transaction as decimal ASCII, most significant digit first,
// no leading zeros, a '-' ahead of negative values in signed mode, then the terminator
// character with last set and length giving the whole run. One word at a time: after
// acceptance a shift-and-add-3 unit takes the word one input bit per cycle, leading zero
// digits are then dropped one per cycle, and the characters leave one per cycle through
// an output register while out_stall_i is low. The input stalls from acceptance until the
// terminator has entered the output register. Config writes are always taken.
module integer_to_decimal_ascii (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [i2d_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [i2d_pkg::CharW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [i2d_pkg::WordW-1:0]     value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [i2d_pkg::CharW-1:0]     character_o,
  output logic                               last_o,
  output logic      [i2d_pkg::LenW-1:0]      length_o
);

  i2d_pkg::ctl_state_e state_q, state_d;

  logic                      signed_q;
  logic [i2d_pkg::CharW-1:0] term_q;
  logic                      neg_q, neg_d;
  logic                      in_acc;
  logic                      neg_in;
  logic [i2d_pkg::WordW-1:0] mag;
  logic                      dab_done;
  logic [i2d_pkg::BcdW-1:0]  dab_bcd;
  logic                      em_done;
  i2d_pkg::emit_cfg_t        em_cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q <= i2d_pkg::SignedReset;
      term_q   <= i2d_pkg::TermReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        i2d_pkg::CfgSignedMode: signed_q <= cfg_data_i[0];
        i2d_pkg::CfgTermChar:   term_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != i2d_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign neg_in     = signed_q && value_i[i2d_pkg::WordW-1];
  assign mag        = neg_in ? (~value_i + 32'd1) : value_i;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    case (state_q)
      i2d_pkg::ST_IDLE: begin
        if (in_acc) begin
          neg_d   = neg_in;
          state_d = i2d_pkg::ST_CONV;
        end
      end
      i2d_pkg::ST_CONV: begin
        if (dab_done) begin
          state_d = i2d_pkg::ST_EMIT;
        end
      end
      i2d_pkg::ST_EMIT: begin
        if (em_done) begin
          state_d = i2d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2d_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
  end

  assign em_cfg.neg  = neg_q;
  assign em_cfg.term = term_q;

  i2d_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .value_i (mag),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  i2d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dab_done),
    .bcd_i       (dab_bcd),
    .cfg_i       (em_cfg),
    .done_o      (em_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .length_o    (length_o)
  );

endmodule

`default_nettype wire
